### rtl/amid_pkg.sv
package amid_pkg;

  // Default axis sample width and fixed field widths
  localparam int SAMPLE_BITS_DEF = 16;
  localparam int MAG_W           = 16;
  localparam int AXIS_W          = 16;
  localparam int THR_W           = 16;

  // Register reset values in 1/256 g
  localparam logic [THR_W-1:0] IMPACT_THR_RST   = 16'd1280;
  localparam logic [THR_W-1:0] FREEFALL_THR_RST = 16'd64;
  localparam logic [MAG_W-1:0] MAG_MAX          = 16'hFFFF;

  // Register indexes (selected by paddr[2])
  localparam logic REG_IMPACT_THR   = 1'b0;
  localparam logic REG_FREEFALL_THR = 1'b1;

  // Item kinds
  localparam logic KIND_SAMPLE = 1'b0;
  localparam logic KIND_CLEAR  = 1'b1;

  // Last index of the three-axis square sequence (three squares, one drain)
  localparam logic [1:0] SQ_LAST = 2'd3;

  typedef struct packed {
    logic              kind;
    logic [AXIS_W-1:0] accel_x;
    logic [AXIS_W-1:0] accel_y;
    logic [AXIS_W-1:0] accel_z;
  } in_item_t;

  typedef struct packed {
    logic [MAG_W-1:0] magnitude;
    logic [MAG_W-1:0] peak;
    logic             impact;
    logic             freefall;
  } out_item_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SQUARE,
    ST_ROOT,
    ST_HOLD
  } amid_state_t;

  // Handshake between the sequencer and the square-root unit
  typedef struct packed {
    logic start;
  } sqrt_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } sqrt_stat_t;

endpackage

### rtl/amid_isqrt.sv
module amid_isqrt
  import amid_pkg::*;
#(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  sqrt_ctl_t                  ctl,
  input  logic [2*SAMPLE_BITS-1:0]   radicand,
  output sqrt_stat_t                 stat,
  output logic [SAMPLE_BITS-1:0]     root
);

  localparam int RAD_W = 2 * SAMPLE_BITS;
  localparam int REM_W = SAMPLE_BITS + 1;
  localparam int CAT_W = SAMPLE_BITS + 3;
  localparam int CNT_W = $clog2(SAMPLE_BITS + 1);
  localparam logic [CNT_W-1:0] STEPS = CNT_W'(SAMPLE_BITS);
  localparam logic [CNT_W-1:0] ONE   = CNT_W'(1);

  logic [RAD_W-1:0]       rad_r, rad_nxt;
  logic [REM_W-1:0]       rem_r, rem_nxt;
  logic [SAMPLE_BITS-1:0] root_r, root_nxt;
  logic [CNT_W-1:0]       cnt_r, cnt_nxt;
  logic                   busy_r, busy_nxt;
  logic                   done_r, done_nxt;

  logic [CAT_W-1:0] rem_cat;
  logic [CAT_W-1:0] trial;
  logic [CAT_W-1:0] diff;
  logic             fits;

  // One root bit per step: bring down two radicand bits, try subtracting 4*root+1
  always_comb begin
    rem_cat = {rem_r, rad_r[RAD_W-1 -: 2]};
    trial   = {1'b0, root_r, 2'b01};
    diff    = rem_cat - trial;
    fits    = (rem_cat >= trial);

    rad_nxt  = rad_r;
    rem_nxt  = rem_r;
    root_nxt = root_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;

    if (ctl.start) begin
      rad_nxt  = radicand;
      rem_nxt  = '0;
      root_nxt = '0;
      cnt_nxt  = STEPS;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      rad_nxt  = {rad_r[RAD_W-3:0], 2'b00};
      rem_nxt  = fits ? diff[REM_W-1:0] : rem_cat[REM_W-1:0];
      root_nxt = {root_r[SAMPLE_BITS-2:0], fits};
      cnt_nxt  = cnt_r - ONE;
      if (cnt_r == ONE) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  // Hold control state under reset, datapath runs free
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rad_r  <= rad_nxt;
    rem_r  <= rem_nxt;
    root_r <= root_nxt;
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign root      = root_r;

`ifndef SYNTHESIS
  a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> $past(busy_r))
    else $error("square root done without a preceding busy step");

  a_not_both: assert property (@(posedge clk) disable iff (!rst_n)
    !(done_r && busy_r))
    else $error("square root busy and done at once");

  a_count_live: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> (cnt_r != '0))
    else $error("square root busy with zero steps left");
`endif

endmodule

### rtl/accel_magnitude_impact_detector.sv
// Each sample is squared axis by axis in the shared multiplier, the squares are summed,
// and the one-bit-per-cycle square-root unit takes the root of the sum; the saturated
// root then goes to the output register. A sample is taken only in the idle state, once
// the previous result has been loaded. A clear item zeroes the peak and gives no result.
// Reset (synchronous, active low): thresholds 1280 and 64, peak zero, no result pending.
module accel_magnitude_impact_detector
  import amid_pkg::*;
#(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,

  input  logic        in_valid,
  output logic        in_ready,
  input  in_item_t    in_data,

  output logic        out_valid,
  input  logic        out_ready,
  output out_item_t   out_data,

  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  localparam int SB    = SAMPLE_BITS;
  localparam int EXT_W = (SB > AXIS_W) ? SB : AXIS_W;
  localparam int RT_W  = (SB > MAG_W) ? SB : MAG_W;

  // ---------------- configuration registers ----------------
  logic [THR_W-1:0] impact_thr_r;
  logic [THR_W-1:0] freefall_thr_r;
  logic             cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;

  // Drop a zero impact threshold, keep the old one
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      impact_thr_r   <= IMPACT_THR_RST;
      freefall_thr_r <= FREEFALL_THR_RST;
    end else if (cfg_wr) begin
      if (cfg_paddr[2] == REG_IMPACT_THR) begin
        if (cfg_pwdata[THR_W-1:0] != '0) begin
          impact_thr_r <= cfg_pwdata[THR_W-1:0];
        end
      end else begin
        freefall_thr_r <= cfg_pwdata[THR_W-1:0];
      end
    end
  end

  always_comb begin
    if (cfg_paddr[2] == REG_IMPACT_THR) begin
      cfg_prdata = {{(32-THR_W){1'b0}}, impact_thr_r};
    end else begin
      cfg_prdata = {{(32-THR_W){1'b0}}, freefall_thr_r};
    end
  end

  // ---------------- axis magnitude ----------------
  function automatic logic [SB-1:0] axis_abs(input logic [AXIS_W-1:0] field);
    logic [EXT_W-1:0] ext;
    logic [SB-1:0]    raw;
    ext = EXT_W'(field);
    raw = ext[SB-1:0];
    return raw[SB-1] ? (~raw + SB'(1)) : raw;
  endfunction

  amid_state_t        state_r, state_nxt;
  logic [SB-1:0]      ax_r, ay_r, az_r;
  logic [1:0]         sq_cnt_r;
  logic [2*SB-1:0]    prod_r;
  logic [2*SB-1:0]    sum_r;
  logic [SB-1:0]      sq_op;
  logic               start_r;
  logic [MAG_W-1:0]   mag_r;
  logic [MAG_W-1:0]   peak_r;
  logic               out_valid_r;
  out_item_t          out_data_r;

  sqrt_ctl_t          sq_ctl;
  sqrt_stat_t         sq_stat;
  logic [SB-1:0]      sq_root;
  logic [RT_W-1:0]    root_ext;
  logic [MAG_W-1:0]   mag_sat;
  logic [MAG_W-1:0]   peak_new;

  logic in_xfer, out_xfer, load_out;

  assign in_ready  = (state_r == ST_IDLE);
  assign in_xfer   = in_valid && in_ready;
  assign out_xfer  = out_valid_r && out_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Pick the axis for the shared multiplier
  always_comb begin
    unique case (sq_cnt_r)
      2'd0:    sq_op = ax_r;
      2'd1:    sq_op = ay_r;
      default: sq_op = az_r;
    endcase
  end

  // Saturate the root to the magnitude width
  assign root_ext = RT_W'(sq_root);
  assign mag_sat  = (root_ext > RT_W'(MAG_MAX)) ? MAG_MAX : root_ext[MAG_W-1:0];
  assign peak_new = (mag_r > peak_r) ? mag_r : peak_r;

  // Sequencer: square three axes, take the root, hand off to the output register
  always_comb begin
    state_nxt = state_r;
    load_out  = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_xfer && (in_data.kind == KIND_SAMPLE)) begin
          state_nxt = ST_SQUARE;
        end
      end
      ST_SQUARE: begin
        if (sq_cnt_r == SQ_LAST) begin
          state_nxt = ST_ROOT;
        end
      end
      ST_ROOT: begin
        if (sq_stat.done) begin
          state_nxt = ST_HOLD;
        end
      end
      ST_HOLD: begin
        if (!out_valid_r || out_ready) begin
          load_out  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      sq_cnt_r    <= '0;
      start_r     <= 1'b0;
      peak_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      start_r <= (state_r == ST_SQUARE) && (sq_cnt_r == SQ_LAST);

      // Advance the square index
      if (in_xfer) begin
        sq_cnt_r <= '0;
      end else if (state_r == ST_SQUARE) begin
        sq_cnt_r <= sq_cnt_r + 2'd1;
      end

      // Clear or update the latched peak
      if (in_xfer && (in_data.kind == KIND_CLEAR)) begin
        peak_r <= '0;
      end else if (load_out) begin
        peak_r <= peak_new;
      end

      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_xfer) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      ax_r  <= axis_abs(in_data.accel_x);
      ay_r  <= axis_abs(in_data.accel_y);
      az_r  <= axis_abs(in_data.accel_z);
      sum_r <= '0;
    end else if (state_r == ST_SQUARE) begin
      if (sq_cnt_r != SQ_LAST) begin
        prod_r <= {{SB{1'b0}}, sq_op} * {{SB{1'b0}}, sq_op};
      end
      if (sq_cnt_r != 2'd0) begin
        sum_r <= sum_r + prod_r;
      end
    end
    if (sq_stat.done) begin
      mag_r <= mag_sat;
    end
    if (load_out) begin
      out_data_r.magnitude <= mag_r;
      out_data_r.peak      <= peak_new;
      out_data_r.impact    <= (mag_r >= impact_thr_r);
      out_data_r.freefall  <= (mag_r <= freefall_thr_r);
    end
  end

  assign sq_ctl.start = start_r;

  amid_isqrt #(
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_isqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (sq_ctl),
    .radicand (sum_r),
    .stat     (sq_stat),
    .root     (sq_root)
  );

`ifndef SYNTHESIS
  a_peak_covers_mag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_data_r.peak >= out_data_r.magnitude))
    else $error("reported peak below reported magnitude");

  a_clear_zeroes_peak: assert property (@(posedge clk) disable iff (!rst_n)
    (in_xfer && (in_data.kind == KIND_CLEAR)) |=> (peak_r == '0))
    else $error("clear item did not zero the peak");

  a_impact_thr_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    impact_thr_r != '0)
    else $error("impact threshold holds zero");

  a_root_done_in_root: assert property (@(posedge clk) disable iff (!rst_n)
    sq_stat.done |-> (state_r == ST_ROOT))
    else $error("square root finished outside the root phase");
`endif

endmodule
